>>> rtl/dqbs_pkg.sv
// shared types and codes for the deque with bag search
// no dependencies
package dqbs_pkg;

    typedef logic signed [31:0] t_word;

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_CONTAINS   = 3'd4;
    localparam logic [2:0] REQ_REMOVE     = 3'd5;
    localparam logic [2:0] REQ_PEEK       = 3'd6;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_LEFT,
        SH_RIGHT
    } t_shift;

    typedef struct packed {
        t_shift shift;
        logic   wr;
        logic   tail;
    } t_cell_ctl;

endpackage

>>> rtl/dqbs_cell.sv
// one storage cell of the deque chain: holds a value, shifts to either neighbor
// depends on dqbs_pkg
module dqbs_cell (
    input  logic                i_clk,
    input  dqbs_pkg::t_cell_ctl i_ctl,
    input  dqbs_pkg::t_word     i_left,
    input  dqbs_pkg::t_word     i_right,
    input  dqbs_pkg::t_word     i_wr_data,
    output dqbs_pkg::t_word     o_value,
    output dqbs_pkg::t_word     o_tap
);

    dqbs_pkg::t_word r_value;
    dqbs_pkg::t_word n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.wr) begin
            n_value = i_wr_data;
        end else begin
            case (i_ctl.shift)
                dqbs_pkg::SH_LEFT:  n_value = i_left;
                dqbs_pkg::SH_RIGHT: n_value = i_right;
                default:            n_value = r_value;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_tap   = i_ctl.tail ? r_value : '0;

endmodule

>>> rtl/deque_with_bag_search_core.sv
// Bounded deque of signed 32-bit words with value search and remove. Entries sit
// in a row of cells, front in cell 0. Push, pop and peek go from idle to the
// report state, where the result is registered once the output is free, as the
// core returns to idle; the input stalls until then. Contains and remove on a
// non-empty queue first pass a scan state: the queue is rotated once through the
// comparator at cell 0, dropping the first match on a remove, so the search length
// is set by that single compare point and the occupancy. A stalled result holds
// its word and delays the next result by the stall. A new word is accepted while
// a finished result still waits.
// depends on dqbs_pkg and dqbs_cell
module deque_with_bag_search_core #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_req_type,
    input  logic signed [31:0]  i_item_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic                o_found,
    output logic signed [31:0]  o_front_value,
    output logic signed [31:0]  o_back_value,
    output logic                o_is_empty,
    output logic [4:0]          o_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_REPORT = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_left, n_left;
    logic [2:0]       r_req, n_req;
    dqbs_pkg::t_word  r_val, n_val;
    logic             r_found, n_found;
    logic [1:0]       r_status, n_status;

    logic             r_out_valid;
    logic [1:0]       r_o_status;
    logic             r_o_found;
    dqbs_pkg::t_word  r_o_front;
    dqbs_pkg::t_word  r_o_back;
    logic             r_o_empty;
    logic [4:0]       r_o_occ;

    dqbs_pkg::t_shift   shift;
    logic               wr_back;
    logic               wr_rot;
    dqbs_pkg::t_word    wr_data;
    dqbs_pkg::t_word    front;
    dqbs_pkg::t_word    back;
    logic               accept;
    logic               report;
    logic               empty;
    logic               full;

    dqbs_pkg::t_word    values [DEPTH];
    dqbs_pkg::t_word    taps   [DEPTH];
    dqbs_pkg::t_cell_ctl ctl   [DEPTH];

    assign empty  = (r_count == '0);
    assign full   = (r_count == CW'(DEPTH));
    assign accept = (r_state == ST_IDLE) && i_in_valid;
    assign report = (r_state == ST_REPORT) && (!r_out_valid || !i_out_stall);
    assign front  = values[0];
    assign wr_data = (r_state == ST_SCAN) ? front : i_item_value;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        n_req    = r_req;
        n_val    = r_val;
        n_found  = r_found;
        n_status = r_status;
        shift    = dqbs_pkg::SH_HOLD;
        wr_back  = 1'b0;
        wr_rot   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_req    = i_req_type;
                    n_val    = i_item_value;
                    n_found  = 1'b0;
                    n_status = dqbs_pkg::STATUS_OK;
                    n_left   = r_count;
                    n_state  = ST_REPORT;
                    case (i_req_type)
                        dqbs_pkg::REQ_PUSH_FRONT: begin
                            if (full) begin
                                n_status = dqbs_pkg::STATUS_OVERFLOW;
                            end else begin
                                shift   = dqbs_pkg::SH_LEFT;
                                n_count = r_count + CW'(1);
                            end
                        end
                        dqbs_pkg::REQ_PUSH_BACK: begin
                            if (full) begin
                                n_status = dqbs_pkg::STATUS_OVERFLOW;
                            end else begin
                                wr_back = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        dqbs_pkg::REQ_POP_FRONT: begin
                            if (empty) begin
                                n_status = dqbs_pkg::STATUS_UNDERFLOW;
                            end else begin
                                shift   = dqbs_pkg::SH_RIGHT;
                                n_count = r_count - CW'(1);
                            end
                        end
                        dqbs_pkg::REQ_POP_BACK: begin
                            if (empty) begin
                                n_status = dqbs_pkg::STATUS_UNDERFLOW;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        dqbs_pkg::REQ_CONTAINS, dqbs_pkg::REQ_REMOVE: begin
                            if (!empty) begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                shift  = dqbs_pkg::SH_RIGHT;
                n_left = r_left - CW'(1);
                if (!r_found && (front == r_val)) begin
                    n_found = 1'b1;
                    if (r_req == dqbs_pkg::REQ_REMOVE) begin
                        n_count = r_count - CW'(1);
                    end else begin
                        wr_rot = 1'b1;
                    end
                end else begin
                    wr_rot = 1'b1;
                end
                if (r_left == CW'(1)) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (report) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            dqbs_pkg::t_word left_in;
            dqbs_pkg::t_word right_in;
            logic            is_tail;

            assign is_tail  = !empty && (CW'(gi) == r_count - CW'(1));
            assign left_in  = (gi == 0) ? i_item_value : values[(gi == 0) ? 0 : gi - 1];
            assign right_in = (gi == DEPTH - 1) ? '0 : values[(gi == DEPTH - 1) ? gi : gi + 1];

            assign ctl[gi].shift = shift;
            assign ctl[gi].wr    = (wr_back && (CW'(gi) == r_count)) || (wr_rot && is_tail);
            assign ctl[gi].tail  = is_tail;

            dqbs_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (ctl[gi]),
                .i_left    (left_in),
                .i_right   (right_in),
                .i_wr_data (wr_data),
                .o_value   (values[gi]),
                .o_tap     (taps[gi])
            );
        end
    endgenerate

    always_comb begin
        back = '0;
        for (int k = 0; k < DEPTH; k++) begin
            back = back | taps[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_found     <= 1'b0;
            r_status    <= dqbs_pkg::STATUS_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_found  <= n_found;
            r_status <= n_status;
            if (report) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_val <= n_val;
        if (report) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_front  <= empty ? '0 : front;
            r_o_back   <= back;
            r_o_empty  <= empty;
            r_o_occ    <= 5'(r_count);
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_found       = r_o_found;
    assign o_front_value = r_o_front;
    assign o_back_value  = r_o_back;
    assign o_is_empty    = r_o_empty;
    assign o_occupancy   = r_o_occ;

endmodule

>>> rtl/dqbs_checker.sv
// port-level checks for the deque with bag search, bound to the top level
// depends on dqbs_pkg and deque_with_bag_search_core
module dqbs_checker #(
    parameter int DEPTH = 16
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [1:0]          o_status,
    input logic                o_found,
    input logic signed [31:0]  o_front_value,
    input logic signed [31:0]  o_back_value,
    input logic                o_is_empty,
    input logic [4:0]          o_occupancy
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_front_value)
            && $stable(o_back_value) && $stable(o_occupancy) && $stable(o_status))
        else $error("stalled result word changed");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left a word pending");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> o_occupancy == 5'd0 && o_front_value == 0
            && o_back_value == 0)
        else $error("empty word reports data");

    a_fail_no_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != dqbs_pkg::STATUS_OK |-> !o_found)
        else $error("failed push or pop reports a match");

    a_single_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (DEPTH < 32) && o_occupancy == 5'd1 |-> o_front_value == o_back_value)
        else $error("single entry with different front and back");

endmodule

bind deque_with_bag_search_core dqbs_checker #(.DEPTH(DEPTH)) u_dqbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_found       (o_found),
    .o_front_value (o_front_value),
    .o_back_value  (o_back_value),
    .o_is_empty    (o_is_empty),
    .o_occupancy   (o_occupancy)
);

>>> test/tb.sv
// testbench for deque_with_bag_search_core: directed and random requests with idling on both sides
// results are predicted by a behavioral deque kept in the testbench and checked in order
// depends on dqbs_pkg and the rtl of deque_with_bag_search_core
module tb;

    localparam int DEPTH = 16;
    localparam logic [2:0] REQ_UNUSED = 3'd7;
    localparam dqbs_pkg::t_word WORD_MIN = 32'sh8000_0000;
    localparam dqbs_pkg::t_word WORD_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [2:0]      req;
        dqbs_pkg::t_word val;
        int              gap;
        bit              drain;
    } t_stim;

    typedef struct {
        logic [1:0]      status;
        logic            found;
        dqbs_pkg::t_word front;
        dqbs_pkg::t_word back;
        logic            empty;
        logic [4:0]      occ;
    } t_outcome;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_stall;
    logic [2:0]      i_req_type = '0;
    dqbs_pkg::t_word i_item_value = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    logic [1:0]      o_status;
    logic            o_found;
    dqbs_pkg::t_word o_front_value;
    dqbs_pkg::t_word o_back_value;
    logic            o_is_empty;
    logic [4:0]      o_occupancy;

    t_stim           stim_q[$];
    t_outcome        result_q[$];
    dqbs_pkg::t_word dq_mem [DEPTH];
    int              dq_count = 0;
    int              n_sent = 0;
    int              n_recv = 0;
    int              n_total = 0;
    int              n_fail = 0;

    deque_with_bag_search_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_item_value  (i_item_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_is_empty    (o_is_empty),
        .o_occupancy   (o_occupancy)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // apply one request to the behavioral deque and return the expected word
    task automatic deque_apply(input logic [2:0] req, input dqbs_pkg::t_word val,
                               output t_outcome res);
        int pos;
        bit hit;
        res.status = dqbs_pkg::STATUS_OK;
        res.found = 1'b0;
        pos = 0;
        hit = 0;
        case (req)
            dqbs_pkg::REQ_PUSH_FRONT, dqbs_pkg::REQ_PUSH_BACK: begin
                if (dq_count >= DEPTH) begin
                    res.status = dqbs_pkg::STATUS_OVERFLOW;
                end else begin
                    if (req == dqbs_pkg::REQ_PUSH_FRONT) begin
                        for (int i = dq_count; i > 0; i--) dq_mem[i] = dq_mem[i-1];
                        dq_mem[0] = val;
                    end else begin
                        dq_mem[dq_count] = val;
                    end
                    dq_count++;
                end
            end
            dqbs_pkg::REQ_POP_FRONT, dqbs_pkg::REQ_POP_BACK: begin
                if (dq_count == 0) begin
                    res.status = dqbs_pkg::STATUS_UNDERFLOW;
                end else begin
                    if (req == dqbs_pkg::REQ_POP_FRONT) begin
                        for (int i = 0; i + 1 < dq_count; i++) dq_mem[i] = dq_mem[i+1];
                    end
                    dq_count--;
                end
            end
            dqbs_pkg::REQ_CONTAINS, dqbs_pkg::REQ_REMOVE: begin
                for (int i = 0; i < dq_count; i++) begin
                    if (!hit && dq_mem[i] == val) begin
                        hit = 1;
                        pos = i;
                    end
                end
                res.found = hit;
                if (req == dqbs_pkg::REQ_REMOVE && hit) begin
                    for (int i = pos; i + 1 < dq_count; i++) dq_mem[i] = dq_mem[i+1];
                    dq_count--;
                end
            end
            default: ;
        endcase
        if (dq_count == 0) begin
            res.front = '0;
            res.back = '0;
            res.empty = 1'b1;
        end else begin
            res.front = dq_mem[0];
            res.back = dq_mem[dq_count-1];
            res.empty = 1'b0;
        end
        res.occ = 5'(dq_count);
    endtask

    task automatic add_item(input logic [2:0] req, input dqbs_pkg::t_word val, input int gap,
                            input bit drain);
        t_stim s;
        s.req = req;
        s.val = val;
        s.gap = gap;
        s.drain = drain;
        stim_q.push_back(s);
        n_total++;
    endtask

    // driver state
    t_stim    drv_next;
    t_stim    drv_cur;
    bit       drv_loaded = 0;
    int       drv_gap = 0;

    always @(posedge i_clk) begin
        t_outcome res;
        bit fire;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && !o_in_stall;
            if (fire) begin
                deque_apply(drv_cur.req, drv_cur.val, res);
                result_q.push_back(res);
                n_sent <= n_sent + 1;
            end
            if (!i_in_valid || fire) begin
                if (!drv_loaded && stim_q.size() > 0) begin
                    drv_next = stim_q.pop_front();
                    drv_loaded = 1;
                    drv_gap = drv_next.gap;
                end
                if (drv_loaded && drv_gap == 0 &&
                    (!drv_next.drain || (!fire && n_sent == n_recv))) begin
                    drv_cur = drv_next;
                    drv_loaded = 0;
                    i_req_type <= drv_next.req;
                    i_item_value <= drv_next.val;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                    if (drv_loaded && drv_gap > 0) drv_gap--;
                end
            end
        end
    end

    // monitor state
    int mon_stall = 0;
    bit mon_calm = 0;

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_recv <= n_recv + 1;
                if (result_q.size() == 0) begin
                    $error("unexpected result word");
                    n_fail++;
                end else begin
                    want = result_q.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        n_fail++;
                    end
                    if (o_found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, o_found);
                        n_fail++;
                    end
                    if (o_front_value !== want.front) begin
                        $error("front_value: expected %0d, got %0d", want.front, o_front_value);
                        n_fail++;
                    end
                    if (o_back_value !== want.back) begin
                        $error("back_value: expected %0d, got %0d", want.back, o_back_value);
                        n_fail++;
                    end
                    if (o_is_empty !== want.empty) begin
                        $error("is_empty: expected %0d, got %0d", want.empty, o_is_empty);
                        n_fail++;
                    end
                    if (o_occupancy !== want.occ) begin
                        $error("occupancy: expected %0d, got %0d", want.occ, o_occupancy);
                        n_fail++;
                    end
                end
                if ($urandom_range(0, 39) == 0) mon_calm = !mon_calm;
                mon_stall = mon_calm ? 0 : $urandom_range(0, 18);
            end else if (mon_stall > 0) begin
                mon_stall--;
            end
            i_out_stall <= (mon_stall > 0);
        end
    end

    initial begin
        int phase_left;
        int push_pct;
        int ph_no;
        int r;
        bit calm;
        bit drain;
        logic [2:0] req;
        dqbs_pkg::t_word val;
        phase_left = 0;
        push_pct = 50;
        ph_no = 0;
        calm = 0;

        // empty queue corners, then extremes and search hits and misses
        add_item(dqbs_pkg::REQ_POP_FRONT, 32'sd7, 0, 0);
        add_item(dqbs_pkg::REQ_POP_BACK, WORD_MAX, 3, 0);
        add_item(dqbs_pkg::REQ_CONTAINS, 32'sd0, 0, 0);
        add_item(dqbs_pkg::REQ_REMOVE, 32'sd0, 1, 0);
        add_item(dqbs_pkg::REQ_PEEK, WORD_MIN, 0, 0);
        add_item(REQ_UNUSED, 32'sd5, 0, 0);
        add_item(dqbs_pkg::REQ_PUSH_FRONT, WORD_MAX, 2, 0);
        add_item(dqbs_pkg::REQ_PUSH_BACK, WORD_MIN, 0, 0);
        add_item(dqbs_pkg::REQ_PUSH_FRONT, 32'sd0, 0, 0);
        add_item(dqbs_pkg::REQ_PUSH_BACK, -32'sd1, 5, 0);
        add_item(dqbs_pkg::REQ_PUSH_BACK, WORD_MAX, 0, 0);
        add_item(dqbs_pkg::REQ_CONTAINS, WORD_MIN, 0, 0);
        add_item(dqbs_pkg::REQ_CONTAINS, 32'sd12345, 0, 0);
        add_item(dqbs_pkg::REQ_REMOVE, WORD_MAX, 0, 0);
        add_item(dqbs_pkg::REQ_REMOVE, 32'sd12345, 4, 0);
        add_item(REQ_UNUSED, 32'sd0, 0, 0);
        add_item(dqbs_pkg::REQ_CONTAINS, WORD_MAX, 0, 0);
        add_item(dqbs_pkg::REQ_POP_BACK, 32'sd0, 0, 0);
        add_item(dqbs_pkg::REQ_POP_FRONT, 32'sd0, 0, 0);
        add_item(dqbs_pkg::REQ_REMOVE, WORD_MIN, 0, 0);
        add_item(dqbs_pkg::REQ_PEEK, 32'sd0, 0, 0);
        add_item(dqbs_pkg::REQ_POP_FRONT, 32'sd0, 0, 0);
        add_item(dqbs_pkg::REQ_REMOVE, -32'sd1, 0, 0);

        // random phases leaning toward filling, draining or mixed traffic
        for (int n = 0; n < 950; n++) begin
            drain = 0;
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 45;
                endcase
                calm = ($urandom_range(0, 3) == 0);
                ph_no++;
                drain = (ph_no % 6 == 1);
            end
            r = $urandom_range(0, 99);
            if (r < push_pct) begin
                req = $urandom_range(0, 1) ? dqbs_pkg::REQ_PUSH_BACK : dqbs_pkg::REQ_PUSH_FRONT;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    req = $urandom_range(0, 1) ? dqbs_pkg::REQ_POP_BACK
                                               : dqbs_pkg::REQ_POP_FRONT;
                end
                else if (r < 65) req = dqbs_pkg::REQ_CONTAINS;
                else if (r < 87) req = dqbs_pkg::REQ_REMOVE;
                else if (r < 97) req = dqbs_pkg::REQ_PEEK;
                else req = REQ_UNUSED;
            end
            // small pool so searches hit and duplicates appear
            case ($urandom_range(0, 9))
                0: val = WORD_MIN;
                1: val = WORD_MAX;
                2: val = 32'sd0;
                3: val = -32'sd1;
                4, 5, 6: val = dqbs_pkg::t_word'($urandom_range(0, 5)) - 32'sd3;
                default: val = dqbs_pkg::t_word'($urandom);
            endcase
            add_item(req, val, calm ? 0 : $urandom_range(0, 18), drain);
            phase_left--;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_recv != n_total) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (result_q.size() != 0) begin
            $error("%0d result words never arrived", result_q.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> deque_with_bag_search_core.f
rtl/dqbs_pkg.sv
rtl/dqbs_cell.sv
rtl/deque_with_bag_search_core.sv
rtl/dqbs_checker.sv
test/tb.sv
